/* rtl/core/bgr_unpack_scale_to_rgb_assert.svh */
// Assertion macros for the packed BGR24 to RGB gearbox.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef BGR_UNPACK_SCALE_TO_RGB_ASSERT_SVH
`define BGR_UNPACK_SCALE_TO_RGB_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BGRUS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bgrus: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BGRUS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bgrus: next-cycle check failed");

`endif

/* rtl/core/bgrus_pkg.sv */
// Shared types, constants and the divide-by-255 helper for the BGR24 gearbox.
// No dependencies.
package bgrus_pkg;

    localparam int NUM_LANES  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int DIM_W      = 12;
    localparam int CHAN_W     = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_SCALE_MAX    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } rgb_t;

    typedef struct packed {
        logic [1:0] count;
        logic       last_hit;
    } grp_meta_t;

    typedef struct packed {
        logic [1:0] carry_count;
        logic       frame_start;
        logic       last_now;
        logic       word_ok;
        logic       grp_valid;
    } gbx_status_t;

    // floor(x / 255) for x up to 255*255
    function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] x);
        logic [2*CHAN_W:0] t;
        t = {1'b0, x} + (2*CHAN_W+1)'(x >> CHAN_W) + (2*CHAN_W+1)'(1);
        return t[2*CHAN_W-1:CHAN_W];
    endfunction

endpackage

/* rtl/core/bgrus_gearbox.sv */
// Byte gearbox: joins carried bytes to each word, splits pixels across lanes,
// tracks the frame position and holds the group descriptor. Uses bgrus_pkg.
module bgrus_gearbox
    import bgrus_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 224,
    parameter int IMAGE_HEIGHT = 224
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [63:0]       packed_word,
    input  logic [DIM_W-1:0]  frame_width,
    input  logic [DIM_W-1:0]  frame_height,
    input  logic              grp_take,
    output logic              lane_load,
    output rgb_t              lane_pix [NUM_LANES],
    output grp_meta_t         grp_meta,
    output gbx_status_t       status
);

    localparam int FRAME_PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int PIX_W        = $clog2(FRAME_PIXELS);

    logic [15:0]      carry_bytes_reg, carry_bytes_next;
    logic [1:0]       carry_count_reg, carry_count_next;
    logic [PIX_W-1:0] pixel_index_reg, pixel_index_next;
    logic             grp_valid_reg, grp_valid_next;
    grp_meta_t        meta_reg, meta_next;

    logic [79:0]      bytes;
    logic [1:0]       nat_cnt;
    logic [NUM_LANES-1:0] lane_last;
    logic             word_ok;
    logic             accept;
    logic             hit;
    logic [1:0]       cnt;

    always_comb
    begin
        word_ok = ({1'b0, frame_width} == (DIM_W+1)'(IMAGE_WIDTH)) &&
                  ({1'b0, frame_height} == (DIM_W+1)'(IMAGE_HEIGHT));
        in_stall = grp_valid_reg && !grp_take;
        accept   = in_valid && !in_stall;

        case (carry_count_reg)
            2'd0:    bytes = {16'h0000, packed_word};
            2'd1:    bytes = {8'h00, packed_word, carry_bytes_reg[7:0]};
            default: bytes = {packed_word, carry_bytes_reg};
        endcase
        nat_cnt = (carry_count_reg == 2'd0) ? 2'd2 : 2'd3;

        for (int j = 0; j < NUM_LANES; j++)
        begin
            lane_pix[j].b = bytes[24*j +: 8];
            lane_pix[j].g = bytes[24*j+8 +: 8];
            lane_pix[j].r = bytes[24*j+16 +: 8];
            lane_last[j]  = (pixel_index_reg == PIX_W'(FRAME_PIXELS - 1 - j));
        end

        hit = 1'b1;
        if (lane_last[0])
            cnt = 2'd1;
        else if (lane_last[1])
            cnt = 2'd2;
        else if (lane_last[2] && nat_cnt == 2'd3)
            cnt = 2'd3;
        else
        begin
            hit = 1'b0;
            cnt = nat_cnt;
        end

        carry_bytes_next = carry_bytes_reg;
        carry_count_next = carry_count_reg;
        pixel_index_next = pixel_index_reg;
        meta_next        = meta_reg;
        grp_valid_next   = grp_take ? 1'b0 : grp_valid_reg;
        lane_load        = accept && word_ok;

        if (lane_load)
        begin
            grp_valid_next     = 1'b1;
            meta_next.count    = cnt;
            meta_next.last_hit = hit;
            if (hit)
            begin
                carry_bytes_next = 16'h0000;
                carry_count_next = 2'd0;
                pixel_index_next = '0;
            end
            else
            begin
                pixel_index_next = pixel_index_reg + PIX_W'(nat_cnt);
                case (carry_count_reg)
                    2'd0:
                    begin
                        carry_bytes_next = packed_word[63:48];
                        carry_count_next = 2'd2;
                    end
                    2'd1:
                    begin
                        carry_bytes_next = 16'h0000;
                        carry_count_next = 2'd0;
                    end
                    default:
                    begin
                        carry_bytes_next = {8'h00, packed_word[63:56]};
                        carry_count_next = 2'd1;
                    end
                endcase
            end
        end

        grp_meta             = meta_reg;
        status.carry_count   = carry_count_reg;
        status.frame_start   = (pixel_index_reg == '0);
        status.last_now      = hit;
        status.word_ok       = word_ok;
        status.grp_valid     = grp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_bytes_reg <= 16'h0000;
            carry_count_reg <= 2'd0;
            pixel_index_reg <= '0;
            grp_valid_reg   <= 1'b0;
            meta_reg        <= '0;
        end
        else
        begin
            carry_bytes_reg <= carry_bytes_next;
            carry_count_reg <= carry_count_next;
            pixel_index_reg <= pixel_index_next;
            grp_valid_reg   <= grp_valid_next;
            meta_reg        <= meta_next;
        end
    end

endmodule

/* rtl/core/bgrus_lane.sv */
// One scaling lane: registers v*scale_max per channel, then divides by 255.
// Uses bgrus_pkg.
module bgrus_lane
    import bgrus_pkg::*;
(
    input  logic              clk,
    input  logic              load,
    input  rgb_t              pix_in,
    input  logic [CHAN_W-1:0] scale_max,
    output rgb_t              pix_out
);

    logic [2*CHAN_W-1:0] prod_r_reg, prod_g_reg, prod_b_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_r_reg <= pix_in.r * scale_max;
            prod_g_reg <= pix_in.g * scale_max;
            prod_b_reg <= pix_in.b * scale_max;
        end
    end

    always_comb
    begin
        pix_out.r = div255(prod_r_reg);
        pix_out.g = div255(prod_g_reg);
        pix_out.b = div255(prod_b_reg);
    end

endmodule

/* rtl/core/bgrus_merge.sv */
// Merge stage: collects the lane results of one group and sends them out
// one pixel per transfer, flagging the frame's last pixel. Uses bgrus_pkg.
module bgrus_merge
    import bgrus_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              grp_valid,
    input  grp_meta_t         grp_meta,
    input  rgb_t              lane_res [NUM_LANES],
    output logic              grp_take,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CHAN_W-1:0] red_scaled,
    output logic [CHAN_W-1:0] green_scaled,
    output logic [CHAN_W-1:0] blue_scaled,
    output logic              last_pixel
);

    logic       valid_reg, valid_next;
    logic [1:0] pos_reg, pos_next;
    grp_meta_t  meta_reg, meta_next;
    rgb_t       pix_reg [NUM_LANES];
    logic       final_px;
    logic       load;

    always_comb
    begin
        final_px   = (pos_reg == meta_reg.count - 2'd1);
        grp_take   = !valid_reg || (!out_stall && final_px);
        load       = grp_take && grp_valid;
        valid_next = valid_reg;
        pos_next   = pos_reg;
        meta_next  = meta_reg;
        if (grp_take)
        begin
            valid_next = grp_valid;
            pos_next   = 2'd0;
            if (grp_valid)
                meta_next = grp_meta;
        end
        else if (!out_stall)
            pos_next = pos_reg + 2'd1;

        out_valid    = valid_reg;
        red_scaled   = pix_reg[pos_reg].r;
        green_scaled = pix_reg[pos_reg].g;
        blue_scaled  = pix_reg[pos_reg].b;
        last_pixel   = meta_reg.last_hit && final_px;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= 2'd0;
            meta_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
            meta_reg  <= meta_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            pix_reg <= lane_res;
    end

endmodule

/* rtl/core/bgr_unpack_scale_to_rgb.sv */
// Top level of the packed BGR24 to RGB gearbox with channel scaling.
// Depends on bgrus_pkg, bgrus_gearbox, bgrus_lane, bgrus_merge and the assert header.
//
// Each 64-bit word yields up to three R,G,B pixels (two or three away from a
// frame's end), one per output transfer, as words alternate two, three, three
// pixels; the output registers of the merge stage send one pixel per cycle
// while out_stall is low. A word is taken while the previous group is still
// being sent; a word's pixels pass through the lane product registers and
// then the merge stage's output registers. Words that arrive while
// frame_width or frame_height differ from the built size are taken and
// dropped. Configuration may be written only while idle.
`include "bgr_unpack_scale_to_rgb_assert.svh"
module bgr_unpack_scale_to_rgb
    import bgrus_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 224,
    parameter int IMAGE_HEIGHT = 224
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [63:0]           packed_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CHAN_W-1:0]     red_scaled,
    output logic [CHAN_W-1:0]     green_scaled,
    output logic [CHAN_W-1:0]     blue_scaled,
    output logic                  last_pixel
);

    logic [DIM_W-1:0]  frame_width_reg;
    logic [DIM_W-1:0]  frame_height_reg;
    logic [CHAN_W-1:0] scale_max_reg;

    logic        grp_take;
    logic        lane_load;
    rgb_t        lane_pix [NUM_LANES];
    rgb_t        lane_res [NUM_LANES];
    grp_meta_t   grp_meta;
    gbx_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_W'(224);
            frame_height_reg <= DIM_W'(224);
            scale_max_reg    <= CHAN_W'(255);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_W-1:0];
                REG_SCALE_MAX:    scale_max_reg    <= cfg_data[CHAN_W-1:0];
                default:          ;
            endcase
        end
    end

    bgrus_gearbox #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_gearbox (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .packed_word  (packed_word),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .grp_take     (grp_take),
        .lane_load    (lane_load),
        .lane_pix     (lane_pix),
        .grp_meta     (grp_meta),
        .status       (status)
    );

    for (genvar j = 0; j < NUM_LANES; j++)
    begin : g_lane
        bgrus_lane u_lane (
            .clk       (clk),
            .load      (lane_load),
            .pix_in    (lane_pix[j]),
            .scale_max (scale_max_reg),
            .pix_out   (lane_res[j])
        );
    end

    bgrus_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .grp_valid    (status.grp_valid),
        .grp_meta     (grp_meta),
        .lane_res     (lane_res),
        .grp_take     (grp_take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red_scaled   (red_scaled),
        .green_scaled (green_scaled),
        .blue_scaled  (blue_scaled),
        .last_pixel   (last_pixel)
    );

    `BGRUS_ASSERT_NOW(a_stall_needs_group, in_stall, status.grp_valid)
    `BGRUS_ASSERT_NOW(a_carry_in_range, 1'b1, status.carry_count != 2'd3)
    `BGRUS_ASSERT_NEXT(a_frame_wrap, lane_load && status.last_now,
        status.frame_start && status.carry_count == 2'd0)
    `BGRUS_ASSERT_NEXT(a_drop_keeps_pos, in_valid && !in_stall && !status.word_ok,
        $stable(status.carry_count) && $stable(status.frame_start))

endmodule

/* verif/tb_bgr_unpack_scale_to_rgb.sv */
// Self-checking testbench for bgr_unpack_scale_to_rgb: drives 64-bit BGR24 words and
// checks each scaled R,G,B pixel against an in-bench gearbox predictor.
// Depends on bgrus_pkg and the RTL of the block only.
`timescale 1ns / 1ps
module tb_bgr_unpack_scale_to_rgb;
    import bgrus_pkg::*;

    localparam int IMG_W        = 224;
    localparam int IMG_H        = 224;
    localparam int FRAME_PIXELS = IMG_W * IMG_H;
    localparam int SETTLE       = 8;
    localparam int HOLD_CYCLES  = 150;
    localparam int RAND_WORDS   = 128;
    localparam longint TIMEOUT_NS = 64'd1_000_000;

    typedef struct {
        rgb_t color;
        logic last;
    } pixel_exp_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [63:0]           packed_word = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [CHAN_W-1:0]     red_scaled;
    logic [CHAN_W-1:0]     green_scaled;
    logic [CHAN_W-1:0]     blue_scaled;
    logic                  last_pixel;

    // shadow registers and gearbox state of the predictor
    int unsigned shadow_width = 224;
    int unsigned shadow_height = 224;
    int unsigned shadow_scale = 255;
    logic [15:0] carry_bytes_m = '0;
    int unsigned carry_cnt_m = 0;
    int unsigned pixel_pos_m = 0;

    logic [63:0] word_feed_q[$];
    pixel_exp_t  pixel_expect_q[$];

    int unsigned words_sent = 0;
    int unsigned words_taken = 0;
    int unsigned words_dropped = 0;
    int unsigned pixels_checked = 0;
    int unsigned frames_ended = 0;
    int unsigned mismatches = 0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_req = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    pixel_exp_t  want;

    bgr_unpack_scale_to_rgb #(
        .IMAGE_WIDTH  (IMG_W),
        .IMAGE_HEIGHT (IMG_H)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .packed_word  (packed_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .red_scaled   (red_scaled),
        .green_scaled (green_scaled),
        .blue_scaled  (blue_scaled),
        .last_pixel   (last_pixel)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [7:0] scale_chan(input logic [7:0] v);
        int unsigned prod;
        prod = int'(v) * shadow_scale;
        return 8'(prod / 255);
    endfunction

    task automatic unpack_expected_pixels(input logic [63:0] word);
        logic [7:0]  stream[10];
        int unsigned total;
        int unsigned pos;
        int unsigned emitted;
        pixel_exp_t  px;
        if (shadow_width != IMG_W || shadow_height != IMG_H)
        begin
            words_dropped++;
            return;
        end
        for (int i = 0; i < carry_cnt_m; i++)
            stream[i] = carry_bytes_m[8*i +: 8];
        for (int i = 0; i < 8; i++)
            stream[carry_cnt_m + i] = word[8*i +: 8];
        total = carry_cnt_m + 8;
        pos = 0;
        emitted = 0;
        while (total - pos >= 3 && emitted < 3)
        begin
            px.color.b = scale_chan(stream[pos]);
            px.color.g = scale_chan(stream[pos + 1]);
            px.color.r = scale_chan(stream[pos + 2]);
            px.last = (pixel_pos_m + 1 >= FRAME_PIXELS);
            pixel_expect_q.push_back(px);
            emitted++;
            pos += 3;
            if (px.last)
            begin
                // drop padding and carried bytes at the frame boundary
                pixel_pos_m = 0;
                carry_bytes_m = '0;
                carry_cnt_m = 0;
                frames_ended++;
                return;
            end
            pixel_pos_m++;
        end
        carry_cnt_m = total - pos;
        carry_bytes_m = '0;
        if (carry_cnt_m > 0)
            carry_bytes_m[7:0] = stream[pos];
        if (carry_cnt_m > 1)
            carry_bytes_m[15:8] = stream[pos + 1];
    endtask

    // input side: accept at rising edge, present at falling edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            unpack_expected_pixels(packed_word);
            words_taken++;
        end
    end

    always @(negedge clk)
    begin
        if (!in_valid || words_taken == words_sent)
        begin
            if (word_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                packed_word <= word_feed_q.pop_front();
                in_valid <= 1'b1;
                words_sent++;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output side: long hold-off on request, else random stalls
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic flag_mismatch(input string what, input pixel_exp_t exp_px);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: expected r=%02h g=%02h b=%02h last=%b,",
                     $realtime, what, exp_px.color.r, exp_px.color.g, exp_px.color.b,
                     exp_px.last, " got r=%02h g=%02h b=%02h last=%b",
                     red_scaled, green_scaled, blue_scaled, last_pixel);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            pixels_checked++;
            if (pixel_expect_q.size() == 0)
            begin
                want = '{color: '0, last: 1'b0};
                flag_mismatch("pixel with none pending", want);
            end
            else
            begin
                want = pixel_expect_q.pop_front();
                if (red_scaled !== want.color.r || green_scaled !== want.color.g ||
                    blue_scaled !== want.color.b || last_pixel !== want.last)
                    flag_mismatch("pixel mismatch", want);
            end
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  shadow_width = value & 12'hFFF;
            REG_FRAME_HEIGHT: shadow_height = value & 12'hFFF;
            REG_SCALE_MAX:    shadow_scale = value & 8'hFF;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (word_feed_q.size() != 0 || in_valid || pixel_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic push_random(input int unsigned n);
        for (int i = 0; i < n; i++)
            word_feed_q.push_back({$urandom, $urandom});
    endtask

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: byte order, channel extremes, scale corners, size mismatch
        send_idle_pct = 6;
        recv_idle_pct = 87;
        word_feed_q.push_back(64'h0000_0000_0000_0000);
        word_feed_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        word_feed_q.push_back(64'h0706_0504_0302_0100);
        word_feed_q.push_back(64'h0123_4567_89AB_CDEF);
        word_feed_q.push_back(64'h00FF_00FF_00FF_00FF);
        word_feed_q.push_back(64'h8001_7F80_FE01_807F);
        wait_drained();
        write_reg(REG_SCALE_MAX, 0);
        word_feed_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        word_feed_q.push_back(64'hFEDC_BA98_7654_3210);
        word_feed_q.push_back(64'h5555_AAAA_5555_AAAA);
        wait_drained();
        write_reg(REG_SCALE_MAX, 1);
        word_feed_q.push_back(64'hFFFE_FFFE_01FF_0100);
        wait_drained();
        write_reg(REG_SCALE_MAX, 128);
        word_feed_q.push_back(64'hFF80_7F01_00FF_8040);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 0);
        word_feed_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        word_feed_q.push_back(64'h1234_5678_9ABC_DEF0);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 4095);
        word_feed_q.push_back(64'h0F0F_0F0F_0F0F_0F0F);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, IMG_W);
        write_reg(REG_FRAME_HEIGHT, 0);
        word_feed_q.push_back(64'hF0F0_F0F0_F0F0_F0F0);
        wait_drained();
        write_reg(REG_FRAME_HEIGHT, 4095);
        word_feed_q.push_back(64'hA5A5_A5A5_A5A5_A5A5);
        wait_drained();
        write_reg(REG_FRAME_HEIGHT, IMG_H);
        write_reg(REG_SCALE_MAX, 254);
        word_feed_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        word_feed_q.push_back(64'h0102_0304_0506_0708);
        wait_drained();

        // random, receiver mostly stalled; pause the sender until drained midway
        write_reg(REG_SCALE_MAX, $urandom_range(255));
        push_random(70);
        wait_drained();
        push_random(RAND_WORDS - 70);
        wait_drained();

        // random, sender mostly idle; a mismatched stretch in between
        send_idle_pct = 87;
        recv_idle_pct = 6;
        write_reg(REG_SCALE_MAX, 255);
        push_random(60);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, IMG_W - 1);
        push_random(10);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, IMG_W);
        write_reg(REG_SCALE_MAX, $urandom_range(1, 254));
        push_random(RAND_WORDS - 60);
        wait_drained();

        // no idling; long output hold-off while words keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_SCALE_MAX, $urandom_range(255));
        push_random(RAND_WORDS);
        hold_req++;
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Transferred %0d words (%0d dropped on size mismatch), checked %0d pixels,",
                 words_taken, words_dropped, pixels_checked);
        $display("crossed %0d frame end(s), %0d mismatches.", frames_ended, mismatches);
        if (mismatches == 0 && pixel_expect_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
